// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion that is switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion that also runs through reset
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bgpr_pkg.sv =====
// types and constants shared by the glyph renderer modules
`timescale 1ns / 1ps
`default_nettype none

package bgpr_pkg;

    localparam int BYTE_BITS = 8;
    localparam int BIT_IDX_W = $clog2(BYTE_BITS);

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [1:0] {
        FUNC_START  = 2'd0,
        FUNC_HEADER = 2'd1,
        FUNC_BITMAP = 2'd2,
        FUNC_END    = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH = 2'd0,
        CFG_CHAR_HEIGHT  = 2'd1,
        CFG_CHAR_SPACING = 2'd2,
        CFG_FG_COLOR     = 2'd3
    } t_cfg_idx;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_DONE  = 1'b1;

    // one queued job: a masked bitmap byte or a done report
    typedef struct packed {
        logic                 kind;
        logic [BYTE_BITS-1:0] mask;
        logic [15:0]          x_base;
        logic [15:0]          y;
        logic [31:0]          color;
        logic [15:0]          count;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

`default_nettype wire

// ===== rtl/bgpr_front.sv =====
// front end: config registers, cursor state and job generation per input beat
`timescale 1ns / 1ps
`default_nettype none

module bgpr_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr,
    input  wire logic [1:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    input  wire logic          i_accept,
    input  wire logic [1:0]    i_func,
    input  wire logic [15:0]   i_start_x,
    input  wire logic [15:0]   i_start_y,
    input  wire logic [7:0]    i_data_byte,
    output logic               o_push,
    output bgpr_pkg::t_job     o_job
);

    logic [15:0] r_screen_width;
    logic [7:0]  r_char_height;
    logic [7:0]  r_char_spacing;
    logic [31:0] r_fg_color;

    logic [15:0] r_cursor_x, n_cursor_x;
    logic [15:0] r_cursor_y, n_cursor_y;
    logic [7:0]  r_glyph_width, n_glyph_width;
    logic [7:0]  r_bits_left, n_bits_left;
    logic [7:0]  r_row_index, n_row_index;
    logic        r_active, n_active;
    logic        r_stopped, n_stopped;
    logic [15:0] r_count, n_count;

    logic [7:0]  nb;
    logic [7:0]  bits_after;
    logic [7:0]  row_next;
    logic [16:0] edge_sum;
    logic [7:0]  fin_width;
    logic        do_finish;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width <= 16'd480;
            r_char_height  <= 8'd16;
            r_char_spacing <= 8'd1;
            r_fg_color     <= 32'hFFFF_FFFF;
        end else if (i_cfg_wr) begin
            case (bgpr_pkg::t_cfg_idx'(i_cfg_index))
                bgpr_pkg::CFG_SCREEN_WIDTH: r_screen_width <= i_cfg_data[15:0];
                bgpr_pkg::CFG_CHAR_HEIGHT:  r_char_height  <= i_cfg_data[7:0];
                bgpr_pkg::CFG_CHAR_SPACING: r_char_spacing <= i_cfg_data[7:0];
                bgpr_pkg::CFG_FG_COLOR:     r_fg_color     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_cursor_x    = r_cursor_x;
        n_cursor_y    = r_cursor_y;
        n_glyph_width = r_glyph_width;
        n_bits_left   = r_bits_left;
        n_row_index   = r_row_index;
        n_active      = r_active;
        n_stopped     = r_stopped;
        n_count       = r_count;
        do_finish     = 1'b0;
        fin_width     = r_glyph_width;

        nb         = (r_bits_left >= 8'(bgpr_pkg::BYTE_BITS)) ?
                     8'(bgpr_pkg::BYTE_BITS) : r_bits_left;
        bits_after = r_bits_left - nb;
        row_next   = r_row_index + 8'd1;
        edge_sum   = {1'b0, r_cursor_x} + {9'd0, i_data_byte};

        o_push       = 1'b0;
        o_job.kind   = bgpr_pkg::KIND_PIXEL;
        o_job.x_base = r_cursor_x + {8'd0, r_bits_left};
        o_job.y      = r_cursor_y + {8'd0, r_row_index};
        o_job.color  = r_fg_color;
        o_job.count  = 16'd0;
        for (int i = 0; i < bgpr_pkg::BYTE_BITS; i++) begin
            o_job.mask[i] = i_data_byte[i] && (8'(i) < nb);
        end

        case (bgpr_pkg::t_func'(i_func))
            bgpr_pkg::FUNC_START: begin
                n_cursor_x  = i_start_x;
                n_cursor_y  = i_start_y;
                n_count     = 16'd0;
                n_active    = 1'b0;
                n_stopped   = 1'b0;
                n_bits_left = 8'd0;
                n_row_index = 8'd0;
            end
            bgpr_pkg::FUNC_HEADER: begin
                if (!r_stopped) begin
                    n_active = 1'b0;
                    if (edge_sum > {1'b0, r_screen_width}) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_glyph_width = i_data_byte;
                        n_bits_left   = i_data_byte;
                        n_row_index   = 8'd0;
                        n_active      = 1'b1;
                        fin_width     = i_data_byte;
                        do_finish     = (i_data_byte == 8'd0) || (r_char_height == 8'd0);
                    end
                end
            end
            bgpr_pkg::FUNC_BITMAP: begin
                if (!r_stopped && r_active) begin
                    o_push      = (o_job.mask != '0);
                    n_bits_left = bits_after;
                    if (bits_after == 8'd0) begin
                        n_row_index = row_next;
                        if (row_next >= r_char_height) begin
                            do_finish = 1'b1;
                        end else begin
                            n_bits_left = r_glyph_width;
                        end
                    end
                end
            end
            bgpr_pkg::FUNC_END: begin
                n_active     = 1'b0;
                n_stopped    = 1'b1;
                o_push       = 1'b1;
                o_job.kind   = bgpr_pkg::KIND_DONE;
                o_job.mask   = '0;
                o_job.x_base = 16'd0;
                o_job.y      = 16'd0;
                o_job.color  = 32'd0;
                o_job.count  = r_count;
            end
            default: ;
        endcase

        if (do_finish) begin
            n_active   = 1'b0;
            n_count    = (r_count == 16'hFFFF) ? r_count : r_count + 16'd1;
            n_cursor_x = r_cursor_x + {8'd0, fin_width} + {8'd0, r_char_spacing};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x    <= '0;
            r_cursor_y    <= '0;
            r_glyph_width <= '0;
            r_bits_left   <= '0;
            r_row_index   <= '0;
            r_active      <= 1'b0;
            r_stopped     <= 1'b0;
            r_count       <= '0;
        end else if (i_accept) begin
            r_cursor_x    <= n_cursor_x;
            r_cursor_y    <= n_cursor_y;
            r_glyph_width <= n_glyph_width;
            r_bits_left   <= n_bits_left;
            r_row_index   <= n_row_index;
            r_active      <= n_active;
            r_stopped     <= n_stopped;
            r_count       <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bgpr_queue.sv =====
// short job queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module bgpr_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire bgpr_pkg::t_job  i_job,
    input  wire logic            i_pop,
    output bgpr_pkg::t_job       o_job,
    output bgpr_pkg::t_q_status  o_status
);

    bgpr_pkg::t_job r_mem [bgpr_pkg::Q_DEPTH];
    logic [bgpr_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [bgpr_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [bgpr_pkg::Q_CNT_W-1:0] r_cnt;
    logic do_push;
    logic do_pop;

    assign o_status.full  = (r_cnt == bgpr_pkg::Q_CNT_W'(bgpr_pkg::Q_DEPTH));
    assign o_status.empty = (r_cnt == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == bgpr_pkg::Q_PTR_W'(bgpr_pkg::Q_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == bgpr_pkg::Q_PTR_W'(bgpr_pkg::Q_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bgpr_back.sv =====
// back end: turns each job into pixel beats or a done beat, one per cycle unless stalled, into the output register
`timescale 1ns / 1ps
`default_nettype none

module bgpr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire bgpr_pkg::t_job  i_job,
    input  wire bgpr_pkg::t_q_status i_q_status,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire logic            i_out_stall,
    output logic                 o_kind,
    output logic [15:0]          o_pixel_x,
    output logic [15:0]          o_pixel_y,
    output logic [31:0]          o_color,
    output logic [15:0]          o_printed_count,
    output logic                 o_last
);

    bgpr_pkg::t_job r_work;
    logic           r_wvalid;
    logic           r_ovalid;

    logic [bgpr_pkg::BIT_IDX_W-1:0] low_idx;
    logic [bgpr_pkg::BYTE_BITS-1:0] rest;
    logic emit;
    logic work_done;
    logic emit_last;

    // the lowest set bit goes first, giving the rightmost remaining pixel
    always_comb begin
        low_idx = '0;
        for (int i = bgpr_pkg::BYTE_BITS - 1; i >= 0; i--) begin
            if (r_work.mask[i]) begin
                low_idx = bgpr_pkg::BIT_IDX_W'(i);
            end
        end
        rest = r_work.mask & ~(bgpr_pkg::BYTE_BITS'(1) << low_idx);
    end

    assign emit      = r_wvalid && (!r_ovalid || !i_out_stall);
    assign emit_last = (r_work.kind == bgpr_pkg::KIND_DONE) || (rest == '0);
    assign work_done = emit && emit_last;
    assign o_pop     = !i_q_status.empty && (!r_wvalid || work_done);
    assign o_out_valid = r_ovalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wvalid <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_wvalid <= 1'b1;
            end else if (work_done) begin
                r_wvalid <= 1'b0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_work <= i_job;
        end else if (emit) begin
            r_work.mask <= rest;
        end
        if (emit) begin
            o_kind          <= r_work.kind;
            o_pixel_x       <= (r_work.kind == bgpr_pkg::KIND_DONE) ? 16'd0 :
                               r_work.x_base - {{(16 - bgpr_pkg::BIT_IDX_W){1'b0}}, low_idx};
            o_pixel_y       <= r_work.y;
            o_color         <= r_work.color;
            o_printed_count <= r_work.count;
            o_last          <= emit_last;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/bitmap_glyph_pixel_renderer.sv =====
// top level of the bitmap glyph pixel renderer
//
//  channel  direction  handshake                    payload
//  in       input      i_in_valid / o_in_stall      func, start_x, start_y, data_byte
//  out      output     o_out_valid / i_out_stall    kind, pixel_x, pixel_y, color,
//                                                   printed_count, last
//  cfg      input      i_cfg_valid / o_cfg_ready    cfg_index, cfg_data
//
// the front end takes one input beat per cycle while the job queue has room
// a bitmap byte of an active glyph with k set bits among its remaining row bits gives k
// pixel beats, one per cycle from the expander into the output register while the
// output is not stalled; an end item gives one beat, other items none
// reset is synchronous and active low, with no clearing pass after it
// output stalls back up into the four-entry queue and then stall the input
`timescale 1ns / 1ps
`default_nettype none

module bitmap_glyph_pixel_renderer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_start_x,
    input  wire logic [15:0] i_start_y,
    input  wire logic [7:0]  i_data_byte,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic             o_kind,
    output logic [15:0]      o_pixel_x,
    output logic [15:0]      o_pixel_y,
    output logic [31:0]      o_color,
    output logic [15:0]      o_printed_count,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    bgpr_pkg::t_job      push_job;
    bgpr_pkg::t_job      pop_job;
    bgpr_pkg::t_q_status q_status;
    logic push;
    logic pop;
    logic in_accept;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = q_status.full;
    assign in_accept   = i_in_valid && !o_in_stall;

    bgpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_func      (i_func),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_job       (push_job)
    );

    bgpr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push && in_accept),
        .i_job    (push_job),
        .i_pop    (pop),
        .o_job    (pop_job),
        .o_status (q_status)
    );

    bgpr_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_job           (pop_job),
        .i_q_status      (q_status),
        .o_pop           (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_pixel_x       (o_pixel_x),
        .o_pixel_y       (o_pixel_y),
        .o_color         (o_color),
        .o_printed_count (o_printed_count),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

// ===== rtl/bgpr_checker.sv =====
// port level checks for the glyph renderer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bgpr_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_stall,
    input wire logic        o_kind,
    input wire logic [15:0] o_pixel_x,
    input wire logic [15:0] o_pixel_y,
    input wire logic [31:0] o_color,
    input wire logic [15:0] o_printed_count,
    input wire logic        o_last
);

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall |=> o_out_valid, "out beat dropped while stalled")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_out_valid && i_out_stall |=> $stable(o_pixel_x) && $stable(o_last), "stalled out beat changed")
    `ASSERT_CLK(a_done_form, i_clk, i_rst_n, o_out_valid && o_kind |-> o_last && o_pixel_x == 16'd0 && o_pixel_y == 16'd0 && o_color == 32'd0, "bad done report")
    `ASSERT_CLK(a_pixel_count, i_clk, i_rst_n, o_out_valid && !o_kind |-> o_printed_count == 16'd0, "pixel beat carries a count")
    `ASSERT_CLK_ALWAYS(a_reset_idle, i_clk, !i_rst_n |=> !o_out_valid, "out valid after reset")

endmodule

bind bitmap_glyph_pixel_renderer bgpr_checker u_bgpr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_kind          (o_kind),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_color         (o_color),
    .o_printed_count (o_printed_count),
    .o_last          (o_last)
);

`default_nettype wire
